// File: rtl/lds_pkg.sv
// Types, constants and the sort-key function shared by the letters-then-digits sorter.
// Depends on nothing; lds_cell and the sorter top level import it.
package lds_pkg;

    localparam logic [7:0] DIGIT_NINE = 8'h39;
    localparam int unsigned KEY_W = 9;

    // One slot of the insertion chain: {group, byte}; group 1 for bytes at or below '9'.
    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
    } t_slot;

    // Broadcast control from the top level to every cell.
    typedef struct packed {
        logic             insert;
        logic             shift;
        logic [KEY_W-1:0] key;
    } t_cell_ctl;

    function automatic logic [KEY_W-1:0] sort_key(input logic [7:0] b);
        return {(b <= DIGIT_NINE), b};
    endfunction

endpackage

// File: rtl/lds_if.sv
// Valid/ready stream interfaces for the sorter's input bytes and sorted results.
// Depends on nothing.
interface lds_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic       final_byte;

    modport source (output valid, output symbol, output final_byte, input ready);
    modport sink   (input valid, input symbol, input final_byte, output ready);
endinterface

interface lds_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] sorted_symbol;
    logic       end_of_run;
    logic       overflowed;

    modport source (output valid, output sorted_symbol, output end_of_run, output overflowed,
                    input ready);
    modport sink   (input valid, input sorted_symbol, input end_of_run, input overflowed,
                    output ready);
endinterface

// File: rtl/lds_cell.sv
// One cell of the insertion-sort chain: holds a key, inserts or shifts toward the head.
// Depends on lds_pkg.
module lds_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lds_pkg::t_cell_ctl i_ctl,
    input  lds_pkg::t_slot    i_left,
    input  logic              i_left_gt,
    input  lds_pkg::t_slot    i_right,
    output lds_pkg::t_slot    o_slot,
    output logic              o_gt
);
    import lds_pkg::*;

    t_slot r_slot;
    t_slot n_slot;

    // Empty cells count as greater, so the new key lands after the last valid one.
    assign o_gt = !r_slot.valid || (r_slot.key > i_ctl.key);

    always_comb begin
        n_slot = r_slot;
        if (i_ctl.insert) begin
            if (o_gt) begin
                if (i_left_gt) begin
                    n_slot = i_left;
                end else begin
                    n_slot.valid = 1'b1;
                    n_slot.key   = i_ctl.key;
                end
            end
        end else if (i_ctl.shift) begin
            n_slot = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot.valid <= 1'b0;
        end else begin
            r_slot.valid <= n_slot.valid;
        end
        r_slot.key <= n_slot.key;
    end

    assign o_slot = r_slot;

endmodule

// File: rtl/letters_then_digits_byte_sorter.sv
// Letters-then-digits byte sorter: a chain of MAX_LEN insertion cells, head at cell 0.
// The first result is offered in the cycle after the final byte's transaction.
// Throughput: one byte per cycle in; the kept bytes of a string then drain in sorted order,
// during which input is held off. Reset clears cell valid bits, drain and drop flags.
// Depends on lds_pkg, lds_if and lds_cell.
module letters_then_digits_byte_sorter #(
    parameter int MAX_LEN = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lds_in_if.sink    i_in,
    lds_out_if.source o_out
);
    import lds_pkg::*;

    t_slot     w_slot [MAX_LEN];
    logic      w_gt   [MAX_LEN];
    t_slot     w_left [MAX_LEN];
    logic      w_lgt  [MAX_LEN];
    t_slot     w_right[MAX_LEN];
    t_cell_ctl w_ctl;

    logic r_drain;
    logic r_drop;
    logic n_drain;
    logic n_drop;

    logic w_in_xact;
    logic w_out_xact;
    logic w_full;
    logic w_last;

    assign w_full     = w_slot[MAX_LEN-1].valid;
    assign w_in_xact  = i_in.valid && i_in.ready;
    assign w_out_xact = o_out.valid && o_out.ready;
    assign w_last     = !w_slot[1].valid;

    assign w_ctl.insert = w_in_xact && !w_full;
    assign w_ctl.shift  = w_out_xact;
    assign w_ctl.key    = sort_key(i_in.symbol);

    genvar g;
    generate
        for (g = 0; g < MAX_LEN; g++) begin : g_cell
            if (g == 0) begin : g_head
                assign w_left[g] = '0;
                assign w_lgt[g]  = 1'b0;
            end else begin : g_mid
                assign w_left[g] = w_slot[g-1];
                assign w_lgt[g]  = w_gt[g-1];
            end
            if (g == MAX_LEN - 1) begin : g_tail
                assign w_right[g] = '0;
            end else begin : g_body
                assign w_right[g] = w_slot[g+1];
            end

            lds_cell u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_ctl     (w_ctl),
                .i_left    (w_left[g]),
                .i_left_gt (w_lgt[g]),
                .i_right   (w_right[g]),
                .o_slot    (w_slot[g]),
                .o_gt      (w_gt[g])
            );
        end
    endgenerate

    always_comb begin
        n_drain = r_drain;
        n_drop  = r_drop;
        if (w_in_xact) begin
            // A byte arriving on a full chain is dropped, final byte included.
            if (w_full) begin
                n_drop = 1'b1;
            end
            if (i_in.final_byte) begin
                n_drain = 1'b1;
            end
        end
        if (w_out_xact && w_last) begin
            n_drain = 1'b0;
            n_drop  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drain <= 1'b0;
            r_drop  <= 1'b0;
        end else begin
            r_drain <= n_drain;
            r_drop  <= n_drop;
        end
    end

    assign i_in.ready          = !r_drain;
    assign o_out.valid         = r_drain && w_slot[0].valid;
    assign o_out.sorted_symbol = w_slot[0].key[7:0];
    assign o_out.end_of_run    = w_last;
    assign o_out.overflowed    = r_drop;

endmodule

// File: rtl/lds_checker.sv
// Port-level checks for the letters-then-digits sorter, bound to its top level.
// Depends on letters_then_digits_byte_sorter's ports only.
module lds_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_in_final,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_symbol,
    input logic       i_out_end,
    input logic       i_out_ovf
);

    // Input is held off while a string drains.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid))
        else $error("input ready while results pending");

    // A final byte always leaves at least one byte to emit.
    a_final_starts_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && i_in_final) |=> i_out_valid)
        else $error("no result after final byte");

    // The last result of a string empties the chain.
    a_end_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && i_out_end) |=> !i_out_valid)
        else $error("result offered after end of run");

    // The drop flag is constant across one string's results.
    a_ovf_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && $past(i_out_valid)) |-> $stable(i_out_ovf))
        else $error("overflow flag changed within a run");

    // Stalled result holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_symbol)
                                           && $stable(i_out_end)))
        else $error("stalled result changed");

endmodule

bind letters_then_digits_byte_sorter lds_checker u_lds_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_in_final   (i_in.final_byte),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_symbol (o_out.sorted_symbol),
    .i_out_end    (o_out.end_of_run),
    .i_out_ovf    (o_out.overflowed)
);
